@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWLF_ASSERT_NOW(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define SWLF_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

@@ rtl/swlf_pkg.sv @@
// Package for the sliding window line fit: field widths, defaults, FSM type.
// No dependencies.
`default_nettype none
package swlf_pkg;
  localparam int DEF_WINDOW_SIZE = 6;
  localparam int DEF_TIME_BITS   = 16;
  localparam int DEF_COORD_BITS  = 12;

  localparam int TIME_W  = 16;
  localparam int COORD_W = 12;
  localparam int ICPT_W  = 40;
  localparam int SLOPE_W = 32;
  localparam int ICPT_FRAC  = 8;
  localparam int SLOPE_FRAC = 16;

  localparam int DIV_QB = 41;
  localparam int CNT_W  = 6;
  localparam int NUM_PROD = 7;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_MUL, ST_DELTA, ST_LOAD, ST_DIV, ST_DONE
  } swlf_state_t;

  typedef struct packed {
    logic start;
    logic step;
  } swlf_div_ctl_t;
endpackage
`default_nettype wire

@@ rtl/swlf_in_if.sv @@
// Input channel: one tracked point sample per transaction.
// Depends on swlf_pkg.
`default_nettype none
interface swlf_in_if import swlf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TIME_W-1:0]  sample_time;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic               detected;
  modport source(output valid, sample_time, point_x, point_y, detected, input ready);
  modport sink(input valid, sample_time, point_x, point_y, detected, output ready);
endinterface
`default_nettype wire

@@ rtl/swlf_out_if.sv @@
// Result channel: line fit coefficients per transaction.
// Depends on swlf_pkg.
`default_nettype none
interface swlf_out_if import swlf_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ICPT_W-1:0]  intercept_x;
  logic signed [SLOPE_W-1:0] slope_x;
  logic signed [ICPT_W-1:0]  intercept_y;
  logic signed [SLOPE_W-1:0] slope_y;
  logic                      fit_valid;
  modport source(output valid, intercept_x, slope_x, intercept_y, slope_y, fit_valid,
                 input ready);
  modport sink(input valid, intercept_x, slope_x, intercept_y, slope_y, fit_valid,
               output ready);
endinterface
`default_nettype wire

@@ rtl/swlf_cell.sv @@
// One window entry (time, x, y); shifts from its neighbor when enabled.
// Depends on swlf_pkg.
`default_nettype none
module swlf_cell import swlf_pkg::*; #(
  parameter int TB = DEF_TIME_BITS,
  parameter int CB = DEF_COORD_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          shift_en,
  input  wire logic [TB-1:0] t_in,
  input  wire logic [CB-1:0] x_in,
  input  wire logic [CB-1:0] y_in,
  output logic      [TB-1:0] t_r,
  output logic      [CB-1:0] x_r,
  output logic      [CB-1:0] y_r
);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r <= '0;
      x_r <= '0;
      y_r <= '0;
    end else if (shift_en) begin
      t_r <= t_in;
      x_r <= x_in;
      y_r <= y_in;
    end
  end
endmodule
`default_nettype wire

@@ rtl/swlf_div.sv @@
// Bit-serial rounding divider: (p - m) / delta with FRAC fraction bits, saturated.
// Depends on swlf_pkg.
`default_nettype none
module swlf_div import swlf_pkg::*; #(
  parameter int P_W   = 66,
  parameter int FRAC  = ICPT_FRAC,
  parameter int OUT_W = ICPT_W
) (
  input  wire logic                 clk,
  input  wire swlf_div_ctl_t        ctl,
  input  wire logic [P_W-1:0]       p,
  input  wire logic [P_W-1:0]       m,
  input  wire logic [P_W-1:0]       delta,
  output logic signed [OUT_W-1:0]   coef
);
  localparam int NUMW = P_W + FRAC + 2;
  localparam int QB   = DIV_QB;
  localparam int RW   = P_W + 1;
  localparam int HW   = NUMW - QB;
  localparam int CW   = (HW > RW) ? HW : RW;
  localparam logic [OUT_W-1:0] LIM_P = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] LIM_N = {1'b1, {(OUT_W-1){1'b0}}};

  logic            neg, ovf, neg_r, ovf_r, qbit, sat;
  logic [P_W-1:0]  mag;
  logic [NUMW-1:0] num;
  logic [RW-1:0]   rem_r, rem_nxt;
  logic [RW:0]     r2, d2x;
  logic [QB-1:0]   qsh_r, q_r;
  logic [OUT_W-1:0] lim, v;

  always_comb begin
    neg = p < m;
    mag = neg ? (m - p) : (p - m);
    num = NUMW'({mag, {(FRAC+1){1'b0}}}) + NUMW'(delta);
    ovf = CW'(num[NUMW-1:QB]) >= CW'({delta, 1'b0});
    d2x = (RW+1)'({delta, 1'b0});
    r2  = {rem_r, qsh_r[QB-1]};
    qbit = r2 >= d2x;
    rem_nxt = qbit ? RW'(r2 - d2x) : RW'(r2);
    lim = neg_r ? LIM_N : LIM_P;
    sat = ovf_r || (q_r > QB'(lim));
    v   = sat ? lim : q_r[OUT_W-1:0];
    coef = neg_r ? -v : v;
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      neg_r <= neg;
      ovf_r <= ovf;
      rem_r <= RW'(num[NUMW-1:QB]);
      qsh_r <= num[QB-1:0];
      q_r   <= '0;
    end else if (ctl.step) begin
      rem_r <= rem_nxt;
      qsh_r <= {qsh_r[QB-2:0], 1'b0};
      q_r   <= {q_r[QB-2:0], qbit};
    end
  end
endmodule
`default_nettype wire

@@ rtl/sliding_window_line_fit.sv @@
// Top level: window cell chain, sum accumulator, shared multiplier, four dividers.
// Depends on swlf_pkg, swlf_in_if, swlf_out_if, swlf_cell, swlf_div, assert_macros.svh.
//
//   channel   dir   handshake      payload
//   in_chan   in    valid/ready    sample_time, point_x, point_y, detected
//   out_chan  out   valid/ready    intercept_x, slope_x, intercept_y, slope_y, fit_valid
//
// A detected sample rotates the cell chain through the sum accumulator, then forms its
// products on the shared multiplier, then runs through the bit-serial dividers before
// its result is loaded. An undetected sample skips these steps. One sample at a time;
// the next is taken while a result waits in the output register.
// Synchronous reset clears the window to zero. Output stalls hold the result register.
`default_nettype none
`include "assert_macros.svh"
module sliding_window_line_fit import swlf_pkg::*; #(
  parameter int WINDOW_SIZE = DEF_WINDOW_SIZE,
  parameter int TIME_BITS   = DEF_TIME_BITS,
  parameter int COORD_BITS  = DEF_COORD_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  swlf_in_if.sink    in_chan,
  swlf_out_if.source out_chan
);
  localparam int TB    = TIME_BITS;
  localparam int CB    = COORD_BITS;
  localparam int NB    = $clog2(WINDOW_SIZE + 1);
  localparam int ST_W  = TB + NB;
  localparam int STT_W = 2 * TB + NB;
  localparam int SV_W  = CB + NB;
  localparam int STV_W = TB + CB + NB;
  localparam int P_W   = STT_W + STV_W;

  swlf_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic in_acc, shift_en, det_r, cnt_clr, out_load;
  swlf_div_ctl_t div_ctl;

  logic [TB-1:0] t_new, head_t;
  logic [CB-1:0] x_new, y_new, head_x, head_y;
  logic [TB-1:0] cell_t [WINDOW_SIZE];
  logic [CB-1:0] cell_x [WINDOW_SIZE];
  logic [CB-1:0] cell_y [WINDOW_SIZE];

  logic [ST_W-1:0]  st_r;
  logic [STT_W-1:0] stt_r;
  logic [SV_W-1:0]  sx_r, sy_r;
  logic [STV_W-1:0] stx_r, sty_r;
  logic [STT_W-1:0] mul_a;
  logic [STV_W-1:0] mul_b;
  logic [P_W-1:0]   prod_r [NUM_PROD];
  logic [P_W-1:0]   delta_r, n_stx, n_sty;

  logic signed [ICPT_W-1:0]  ix, iy;
  logic signed [SLOPE_W-1:0] sx_c, sy_c;
  logic out_valid_r, fit_r;
  logic signed [ICPT_W-1:0]  ix_r, iy_r;
  logic signed [SLOPE_W-1:0] slx_r, sly_r;

  assign in_acc = in_chan.valid && in_chan.ready;
  assign t_new  = TB'(in_chan.sample_time);
  assign x_new  = CB'(in_chan.point_x);
  assign y_new  = CB'(in_chan.point_y);
  assign head_t = (state_r == ST_IDLE) ? t_new : cell_t[WINDOW_SIZE-1];
  assign head_x = (state_r == ST_IDLE) ? x_new : cell_x[WINDOW_SIZE-1];
  assign head_y = (state_r == ST_IDLE) ? y_new : cell_y[WINDOW_SIZE-1];

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    swlf_cell #(.TB(TB), .CB(CB)) u_cell (
      .clk(clk), .rst_n(rst_n), .shift_en(shift_en),
      .t_in((i == 0) ? head_t : cell_t[(i == 0) ? 0 : i-1]),
      .x_in((i == 0) ? head_x : cell_x[(i == 0) ? 0 : i-1]),
      .y_in((i == 0) ? head_y : cell_y[(i == 0) ? 0 : i-1]),
      .t_r(cell_t[i]), .x_r(cell_x[i]), .y_r(cell_y[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    in_chan.ready = 1'b0;
    shift_en      = 1'b0;
    cnt_clr       = 1'b1;
    out_load      = 1'b0;
    div_ctl       = '0;
    case (state_r)
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_acc) begin
          shift_en  = in_chan.detected;
          state_nxt = in_chan.detected ? ST_SUM : ST_DONE;
        end
      end
      ST_SUM: begin
        shift_en = 1'b1;
        cnt_clr  = 1'b0;
        if (cnt_r == CNT_W'(WINDOW_SIZE - 1)) begin
          cnt_clr   = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cnt_clr = 1'b0;
        if (cnt_r == CNT_W'(NUM_PROD - 1)) begin
          cnt_clr   = 1'b1;
          state_nxt = ST_DELTA;
        end
      end
      ST_DELTA: state_nxt = ST_LOAD;
      ST_LOAD: begin
        div_ctl.start = 1'b1;
        state_nxt     = ST_DIV;
      end
      ST_DIV: begin
        div_ctl.step = 1'b1;
        cnt_clr      = 1'b0;
        if (cnt_r == CNT_W'(DIV_QB - 1)) begin
          cnt_clr   = 1'b1;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n)       cnt_r <= '0;
    else if (cnt_clr) cnt_r <= '0;
    else              cnt_r <= cnt_r + 1'b1;
  end

  // sums over the rotating chain tail
  always_ff @(posedge clk) begin
    if (in_acc) begin
      det_r <= in_chan.detected;
      st_r  <= '0;
      stt_r <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      stx_r <= '0;
      sty_r <= '0;
    end else if (state_r == ST_SUM) begin
      st_r  <= st_r + ST_W'(cell_t[WINDOW_SIZE-1]);
      stt_r <= stt_r + STT_W'(STT_W'(cell_t[WINDOW_SIZE-1]) * STT_W'(cell_t[WINDOW_SIZE-1]));
      sx_r  <= sx_r + SV_W'(cell_x[WINDOW_SIZE-1]);
      sy_r  <= sy_r + SV_W'(cell_y[WINDOW_SIZE-1]);
      stx_r <= stx_r + STV_W'(STV_W'(cell_t[WINDOW_SIZE-1]) * STV_W'(cell_x[WINDOW_SIZE-1]));
      sty_r <= sty_r + STV_W'(STV_W'(cell_t[WINDOW_SIZE-1]) * STV_W'(cell_y[WINDOW_SIZE-1]));
    end
  end

  always_comb begin
    case (cnt_r[2:0])
      3'd0: begin mul_a = stt_r;        mul_b = STV_W'(sx_r); end
      3'd1: begin mul_a = STT_W'(st_r); mul_b = stx_r;        end
      3'd2: begin mul_a = stt_r;        mul_b = STV_W'(sy_r); end
      3'd3: begin mul_a = STT_W'(st_r); mul_b = sty_r;        end
      3'd4: begin mul_a = STT_W'(st_r); mul_b = STV_W'(st_r); end
      3'd5: begin mul_a = STT_W'(st_r); mul_b = STV_W'(sx_r); end
      3'd6: begin mul_a = STT_W'(st_r); mul_b = STV_W'(sy_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) prod_r[cnt_r[2:0]] <= P_W'(mul_a) * P_W'(mul_b);
    if (state_r == ST_DELTA) delta_r <= P_W'(P_W'(WINDOW_SIZE) * P_W'(stt_r)) - prod_r[4];
  end

  assign n_stx = P_W'(P_W'(WINDOW_SIZE) * P_W'(stx_r));
  assign n_sty = P_W'(P_W'(WINDOW_SIZE) * P_W'(sty_r));

  swlf_div #(.P_W(P_W), .FRAC(ICPT_FRAC), .OUT_W(ICPT_W)) u_div_ix (
    .clk(clk), .ctl(div_ctl), .p(prod_r[0]), .m(prod_r[1]), .delta(delta_r), .coef(ix));
  swlf_div #(.P_W(P_W), .FRAC(SLOPE_FRAC), .OUT_W(SLOPE_W)) u_div_sx (
    .clk(clk), .ctl(div_ctl), .p(n_stx), .m(prod_r[5]), .delta(delta_r), .coef(sx_c));
  swlf_div #(.P_W(P_W), .FRAC(ICPT_FRAC), .OUT_W(ICPT_W)) u_div_iy (
    .clk(clk), .ctl(div_ctl), .p(prod_r[2]), .m(prod_r[3]), .delta(delta_r), .coef(iy));
  swlf_div #(.P_W(P_W), .FRAC(SLOPE_FRAC), .OUT_W(SLOPE_W)) u_div_sy (
    .clk(clk), .ctl(div_ctl), .p(n_sty), .m(prod_r[6]), .delta(delta_r), .coef(sy_c));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      fit_r <= det_r && (delta_r != '0);
      if (det_r && (delta_r != '0)) begin
        ix_r  <= ix;
        slx_r <= sx_c;
        iy_r  <= iy;
        sly_r <= sy_c;
      end else begin
        ix_r  <= '0;
        slx_r <= '0;
        iy_r  <= '0;
        sly_r <= '0;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.fit_valid   = fit_r;
  assign out_chan.intercept_x = ix_r;
  assign out_chan.slope_x     = slx_r;
  assign out_chan.intercept_y = iy_r;
  assign out_chan.slope_y     = sly_r;

  `SWLF_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_acc, state_r != ST_IDLE,
                    "accepted transaction left the FSM idle")
  `SWLF_ASSERT_NEXT(a_load_valid, clk, rst_n, out_load, out_valid_r,
                    "result load did not raise valid")
  `SWLF_ASSERT_NOW(a_zero_fit, clk, rst_n, out_valid_r && !fit_r,
                   ix_r == '0 && slx_r == '0 && iy_r == '0 && sly_r == '0,
                   "invalid fit with nonzero coefficients")
  `SWLF_ASSERT_NOW(a_no_overrun, clk, rst_n, out_load, !out_valid_r || out_chan.ready,
                   "result overwrote a waiting transaction")
endmodule
`default_nettype wire
